/* hw/rtl/lcdt_pkg.sv */
// Shared types and constants for the LCD mode and line timing block.
// Used by the interfaces, the configuration registers, the timing core and the top level.
package lcdt_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int DOT_W      = 9;
  localparam int LINE_W     = 8;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_HBLANK = 2'd0;
  localparam mode_t MODE_VBLANK = 2'd1;
  localparam mode_t MODE_OAM    = 2'd2;
  localparam mode_t MODE_DRAW   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LCD_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_HBLANK_IRQ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_VBLANK_IRQ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_OAM_IRQ     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_COMPARE_IRQ = 3'd5;

  typedef struct packed {
    logic              lcd_enable;
    logic [LINE_W-1:0] line_compare;
    logic              sel_hblank_irq;
    logic              sel_vblank_irq;
    logic              sel_oam_irq;
    logic              sel_compare_irq;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [LINE_W-1:0] line;
    logic              coincidence;
    logic              stat_irq;
    logic              vblank_irq;
    logic              line_drawn;
  } result_t;

endpackage

/* hw/rtl/lcdt_ifs.sv */
// Handshake channels of the LCD timing block: step input, status output and register writes.
// Depends on lcdt_pkg for field widths and the mode type.
interface lcdt_step_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

interface lcdt_status_if;
  logic                      valid;
  logic                      ready;
  lcdt_pkg::mode_t           mode;
  logic [lcdt_pkg::LINE_W-1:0] line;
  logic                      coincidence;
  logic                      stat_irq;
  logic                      vblank_irq;
  logic                      line_drawn;

  modport source (output valid, output mode, output line, output coincidence,
                  output stat_irq, output vblank_irq, output line_drawn, input ready);
  modport sink   (input valid, input mode, input line, input coincidence,
                  input stat_irq, input vblank_irq, input line_drawn, output ready);
endinterface

interface lcdt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lcdt_pkg::CFG_IDX_W-1:0]  index;
  logic [lcdt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/lcdt_cfg_regs.sv */
// Configuration register file of the LCD timing block.
// Depends on lcdt_pkg and the lcdt_cfg_if interface.
module lcdt_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  lcdt_cfg_if.sink         cfg,
  output lcdt_pkg::cfg_t   regs
);

  // Writes are always taken; an index past the list is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        lcdt_pkg::REG_LCD_ENABLE:      regs.lcd_enable      <= cfg.data[0];
        lcdt_pkg::REG_LINE_COMPARE:    regs.line_compare    <= cfg.data;
        lcdt_pkg::REG_SEL_HBLANK_IRQ:  regs.sel_hblank_irq  <= cfg.data[0];
        lcdt_pkg::REG_SEL_VBLANK_IRQ:  regs.sel_vblank_irq  <= cfg.data[0];
        lcdt_pkg::REG_SEL_OAM_IRQ:     regs.sel_oam_irq     <= cfg.data[0];
        lcdt_pkg::REG_SEL_COMPARE_IRQ: regs.sel_compare_irq <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/lcdt_core.sv */
// Timing core: mode, dot counter, line counter and STAT edge memory with their next-state logic.
// Depends on lcdt_pkg.
module lcdt_core #(
  parameter int DOTS_OAM_SCAN = 80,
  parameter int DOTS_DRAW     = 172,
  parameter int DOTS_PER_LINE = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int TOTAL_LINES   = 154
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               advance,
  input  lcdt_pkg::cfg_t     regs,
  output lcdt_pkg::result_t  result
);

  // Thresholds are compared against a 10-bit sum, so anything above 512 acts as 512.
  localparam int OAM_END  = (DOTS_OAM_SCAN > 512) ? 512 : DOTS_OAM_SCAN;
  localparam int DRAW_END = ((DOTS_OAM_SCAN + DOTS_DRAW) > 512) ? 512
                                                               : (DOTS_OAM_SCAN + DOTS_DRAW);
  localparam int LINE_END = (DOTS_PER_LINE > 512) ? 512 : DOTS_PER_LINE;

  localparam logic [lcdt_pkg::DOT_W:0]    T_OAM   = (lcdt_pkg::DOT_W+1)'(OAM_END);
  localparam logic [lcdt_pkg::DOT_W:0]    T_DRAW  = (lcdt_pkg::DOT_W+1)'(DRAW_END);
  localparam logic [lcdt_pkg::DOT_W:0]    T_LINE  = (lcdt_pkg::DOT_W+1)'(LINE_END);
  localparam logic [lcdt_pkg::LINE_W-1:0] L_VIS   = lcdt_pkg::LINE_W'(VISIBLE_LINES);
  localparam logic [lcdt_pkg::LINE_W-1:0] L_TOTAL = lcdt_pkg::LINE_W'(TOTAL_LINES);

  lcdt_pkg::mode_t              mode;
  logic [lcdt_pkg::DOT_W-1:0]   dot_count;
  logic [lcdt_pkg::LINE_W-1:0]  cur_line;
  logic                         stat_prev;

  lcdt_pkg::mode_t              mode_next;
  logic [lcdt_pkg::DOT_W-1:0]   dot_count_next;
  logic [lcdt_pkg::LINE_W-1:0]  cur_line_next;
  logic                         stat_prev_next;

  logic [lcdt_pkg::DOT_W:0]     dot_sum;
  logic [lcdt_pkg::LINE_W-1:0]  line_inc;
  logic                         sig;
  logic                         stat_irq;
  logic                         vblank_irq;
  logic                         line_drawn;

  assign dot_sum  = {1'b0, dot_count} + (lcdt_pkg::DOT_W+1)'(2);
  assign line_inc = cur_line + lcdt_pkg::LINE_W'(1);

  always_comb begin
    mode_next      = mode;
    dot_count_next = dot_count;
    cur_line_next  = cur_line;
    stat_prev_next = stat_prev;
    sig            = 1'b0;
    stat_irq       = 1'b0;
    vblank_irq     = 1'b0;
    line_drawn     = 1'b0;
    if (!regs.lcd_enable) begin
      stat_prev_next = 1'b0;
    end else if (advance) begin
      dot_count_next = dot_sum[lcdt_pkg::DOT_W-1:0];
      case (mode)
        lcdt_pkg::MODE_OAM: begin
          sig = regs.sel_oam_irq;
          if (dot_sum >= T_OAM) mode_next = lcdt_pkg::MODE_DRAW;
        end
        lcdt_pkg::MODE_DRAW: begin
          if (dot_sum >= T_DRAW) begin
            mode_next  = lcdt_pkg::MODE_HBLANK;
            line_drawn = 1'b1;
          end
        end
        lcdt_pkg::MODE_HBLANK: begin
          sig = regs.sel_hblank_irq;
          if (dot_sum >= T_LINE) begin
            dot_count_next = '0;
            cur_line_next  = line_inc;
            if (line_inc >= L_VIS) begin
              mode_next  = lcdt_pkg::MODE_VBLANK;
              vblank_irq = 1'b1;
            end else begin
              mode_next = lcdt_pkg::MODE_OAM;
            end
          end
        end
        default: begin
          // Vblank also answers to the OAM select.
          sig = regs.sel_vblank_irq | regs.sel_oam_irq;
          if (dot_sum >= T_LINE) begin
            dot_count_next = '0;
            cur_line_next  = line_inc;
            if (line_inc == L_TOTAL) begin
              cur_line_next = '0;
              mode_next     = lcdt_pkg::MODE_OAM;
            end
          end
        end
      endcase
      if (cur_line_next == regs.line_compare) sig = sig | regs.sel_compare_irq;
      stat_irq       = sig & ~stat_prev;
      stat_prev_next = sig;
    end
  end

  always_comb begin
    result.mode        = mode_next;
    result.line        = cur_line_next;
    result.coincidence = (cur_line_next == regs.line_compare);
    result.stat_irq    = stat_irq;
    result.vblank_irq  = vblank_irq;
    result.line_drawn  = line_drawn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= lcdt_pkg::MODE_OAM;
      dot_count <= '0;
      cur_line  <= '0;
      stat_prev <= 1'b0;
    end else if (step) begin
      mode      <= mode_next;
      dot_count <= dot_count_next;
      cur_line  <= cur_line_next;
      stat_prev <= stat_prev_next;
    end
  end

endmodule

/* hw/rtl/lcd_mode_line_timing_top.sv */
// Top level of the LCD mode and line timing block: input register, timing core, result register.
// A step word passes the input register, then the result register; one word per cycle while the sink is ready.
// The dot and line compares and the mode update sit in combinational logic between the two registers.
// Synchronous active-high reset puts the timing at line 0, dot 0, OAM scan, registers cleared.
// Depends on lcdt_pkg, the lcdt interfaces, lcdt_cfg_regs and lcdt_core.
module lcd_mode_line_timing_top #(
  parameter int DOTS_OAM_SCAN = 80,
  parameter int DOTS_DRAW     = 172,
  parameter int DOTS_PER_LINE = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int TOTAL_LINES   = 154
) (
  input  logic          clk,
  input  logic          rst,
  lcdt_step_if.sink     step,
  lcdt_status_if.source status,
  lcdt_cfg_if.sink      cfg
);

  lcdt_pkg::cfg_t    regs;
  lcdt_pkg::result_t result;

  // Input register: holds one step word until the result register can take its status.
  logic in_valid;
  logic in_advance;
  // Result register: holds one status word until the sink takes it.
  logic out_valid;
  lcdt_pkg::result_t out_word;

  logic load;

  // The core's state moves exactly when a status word is written into the result
  // register, so each step word updates the timing once and only once.
  assign load       = in_valid && (!out_valid || status.ready);
  assign step.ready = !in_valid || load;

  lcdt_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lcdt_core #(
    .DOTS_OAM_SCAN (DOTS_OAM_SCAN),
    .DOTS_DRAW     (DOTS_DRAW),
    .DOTS_PER_LINE (DOTS_PER_LINE),
    .VISIBLE_LINES (VISIBLE_LINES),
    .TOTAL_LINES   (TOTAL_LINES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (load),
    .advance (in_advance),
    .regs    (regs),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (step.ready) begin
      in_valid <= step.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid && step.ready) in_advance <= step.advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_word <= result;
  end

  assign status.valid       = out_valid;
  assign status.mode        = out_word.mode;
  assign status.line        = out_word.line;
  assign status.coincidence = out_word.coincidence;
  assign status.stat_irq    = out_word.stat_irq;
  assign status.vblank_irq  = out_word.vblank_irq;
  assign status.line_drawn  = out_word.line_drawn;

endmodule
